[src/blcsd_pkg.sv]
// Shared types and constants for the book level change spike detector.
`default_nettype none
package blcsd_pkg;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned CHG_W   = 32;
  localparam int unsigned WSIZE_W = 9;
  localparam int unsigned PCT_W   = 17;
  localparam int unsigned OBS_W   = 16;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OBS     = 2'd2;

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_BID  = 2'd1;
  localparam logic [1:0] SIDE_ASK  = 2'd2;

  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_BULLISH = 2'd1;
  localparam logic [1:0] DIR_BEARISH = 2'd2;

  // Snapshot summary handed from the front part to the back part.
  typedef struct packed {
    logic              baseline;
    logic [SIZE_W-1:0] magnitude;
    logic [CHG_W-1:0]  signed_change;
    logic [PRICE_W-1:0] price;
    logic [1:0]        side;
  } snap_t;
endpackage
`default_nettype wire

[src/blcsd_if.sv]
// Valid/ready channel interfaces for levels in and results out.
`default_nettype none
interface blcsd_level_if;
  logic        valid;
  logic        ready;
  logic        side;
  logic [30:0] level_size;
  logic [31:0] level_price;
  logic        last_level;
  modport source (output valid, side, level_size, level_price, last_level, input ready);
  modport sink (input valid, side, level_size, level_price, last_level, output ready);
endinterface

interface blcsd_result_if;
  logic        valid;
  logic        ready;
  logic        is_spike;
  logic [1:0]  direction;
  logic [1:0]  winning_side;
  logic [31:0] winning_price;
  logic signed [31:0] signed_change;
  modport source (output valid, is_spike, direction, winning_side, winning_price,
                  signed_change, input ready);
  modport sink (input valid, is_spike, direction, winning_side, winning_price,
                signed_change, output ready);
endinterface
`default_nettype wire

[src/blcsd_front.sv]
// Front part: compares each level with the previous snapshot, tracks the largest change.
`default_nettype none
module blcsd_front #(
  parameter int unsigned BOOK_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               lvl_valid,
  output logic                    lvl_ready,
  input  wire logic               lvl_side,
  input  wire logic [30:0]        lvl_size,
  input  wire logic [31:0]        lvl_price,
  input  wire logic               lvl_last,
  output logic                    snap_valid,
  input  wire logic               snap_ready,
  output blcsd_pkg::snap_t        snap
);
  import blcsd_pkg::*;
  localparam int unsigned AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

  typedef enum logic [1:0] {S_TAKE, S_CMP, S_SEND} state_t;
  state_t state_r;

  logic [SIZE_W-1:0] bid_mem [BOOK_DEPTH];
  logic [SIZE_W-1:0] ask_mem [BOOK_DEPTH];
  logic [SIZE_W-1:0] rd_r;

  logic [CW-1:0] bid_idx_r, ask_idx_r, prev_bid_r, prev_ask_r;
  logic          baseline_r;
  logic          h_side_r, h_last_r, h_cmp_r;
  logic [SIZE_W-1:0]  h_size_r;
  logic [PRICE_W-1:0] h_price_r;
  logic [SIZE_W-1:0]  best_mag_r;
  logic [CHG_W-1:0]   best_chg_r;
  logic [PRICE_W-1:0] best_price_r;
  logic [1:0]         best_side_r;

  logic [CW-1:0] idx_c, pcnt_c;
  logic          in_range_c;
  logic [CHG_W-1:0] diff_c;
  logic [SIZE_W-1:0] mag_c;

  assign idx_c      = lvl_side ? ask_idx_r : bid_idx_r;
  assign pcnt_c     = lvl_side ? prev_ask_r : prev_bid_r;
  assign in_range_c = idx_c < DEPTH_C;
  assign diff_c     = {1'b0, h_size_r} - {1'b0, rd_r};
  assign mag_c      = diff_c[CHG_W-1] ? SIZE_W'(-diff_c) : diff_c[SIZE_W-1:0];

  assign lvl_ready  = (state_r == S_TAKE);
  assign snap_valid = (state_r == S_SEND);
  always_comb begin
    snap.baseline      = !baseline_r;
    snap.magnitude     = best_mag_r;
    snap.signed_change = best_chg_r;
    snap.price         = best_price_r;
    snap.side          = best_side_r;
  end

  // Read old size and write new size at the same index in the accept cycle.
  always_ff @(posedge clk) begin
    if (lvl_valid && lvl_ready && in_range_c) begin
      if (lvl_side) begin
        rd_r <= ask_mem[idx_c[AW-1:0]];
        ask_mem[idx_c[AW-1:0]] <= lvl_size;
      end else begin
        rd_r <= bid_mem[idx_c[AW-1:0]];
        bid_mem[idx_c[AW-1:0]] <= lvl_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
      bid_idx_r <= '0; ask_idx_r <= '0; prev_bid_r <= '0; prev_ask_r <= '0;
      baseline_r <= 1'b0; h_cmp_r <= 1'b0;
      best_mag_r <= '0; best_chg_r <= '0; best_price_r <= '0; best_side_r <= SIDE_NONE;
    end else begin
      case (state_r)
        S_TAKE: begin
          if (lvl_valid) begin
            h_side_r  <= lvl_side;
            h_size_r  <= lvl_size;
            h_price_r <= lvl_price;
            h_last_r  <= lvl_last;
            h_cmp_r   <= in_range_c && baseline_r && (idx_c < pcnt_c);
            if (in_range_c) begin
              if (lvl_side) ask_idx_r <= ask_idx_r + 1'b1;
              else bid_idx_r <= bid_idx_r + 1'b1;
            end
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (h_cmp_r && (mag_c > best_mag_r)) begin
            best_mag_r   <= mag_c;
            best_chg_r   <= diff_c;
            best_price_r <= h_price_r;
            best_side_r  <= h_side_r ? SIDE_ASK : SIDE_BID;
          end
          state_r <= h_last_r ? S_SEND : S_TAKE;
        end
        S_SEND: begin
          if (snap_ready) begin
            baseline_r <= 1'b1;
            prev_bid_r <= bid_idx_r; prev_ask_r <= ask_idx_r;
            bid_idx_r <= '0; ask_idx_r <= '0;
            best_mag_r <= '0; best_chg_r <= '0; best_price_r <= '0;
            best_side_r <= SIDE_NONE;
            state_r <= S_TAKE;
          end
        end
        default: state_r <= S_TAKE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/blcsd_queue.sv]
// Two-entry queue of snapshot summaries between front and back parts.
`default_nettype none
module blcsd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  blcsd_pkg::snap_t   wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output blcsd_pkg::snap_t   rd_data
);
  import blcsd_pkg::*;
  snap_t     mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      push_c, pop_c;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push_c   = wr_valid && wr_ready;
  assign pop_c    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push_c) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_c) wp_r <= ~wp_r;
      if (pop_c) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_c} - {1'b0, pop_c};
    end
  end
endmodule
`default_nettype wire

[src/blcsd_back.sv]
// Back part: rolling window push, rank test and result formatting.
`default_nettype none
module blcsd_back #(
  parameter int unsigned WINDOW_MAX = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [8:0]      cfg_window_size,
  input  wire logic [16:0]     cfg_percentile,
  input  wire logic [15:0]     cfg_min_obs,
  input  wire logic            snap_valid,
  output logic                 snap_ready,
  input  blcsd_pkg::snap_t     snap,
  blcsd_result_if.source       res
);
  import blcsd_pkg::*;
  localparam int unsigned PW = $clog2(WINDOW_MAX);
  localparam int unsigned FW = $clog2(WINDOW_MAX + 1);
  localparam logic [FW-1:0] WMAX_C = FW'(WINDOW_MAX);

  typedef enum logic [2:0] {S_IDLE, S_RANK, S_SCAN, S_DRAIN, S_DONE, S_OUT} state_t;
  state_t state_r;

  logic [SIZE_W-1:0] win_mem [WINDOW_MAX];
  logic [SIZE_W-1:0] rd_r;
  logic [PW-1:0] wpos_r, rpos_r;
  logic [FW-1:0] fill_r, left_r, below_r;
  logic [OBS_W-1:0] obs_r;
  logic [FW+PCT_W-1:0] prod_r;
  logic test_r;
  snap_t s_r;
  logic rd_ok_r;

  logic [FW-1:0] eff_c, fill_nxt;
  logic [16:0] pct_c;
  logic [FW-1:0] k_c;
  logic k_over_c;
  logic [9:0] wsz_c;
  logic grew_c;

  always_comb begin
    wsz_c = {1'b0, cfg_window_size};
    if (wsz_c == 10'd0) wsz_c = 10'd1;
    if (FW >= 10) eff_c = FW'(wsz_c);
    else eff_c = (wsz_c > 10'(WINDOW_MAX)) ? WMAX_C : FW'(wsz_c);
    if (32'(wsz_c) > WINDOW_MAX) eff_c = WMAX_C;
    pct_c = (cfg_percentile > 17'd65536) ? 17'd65536 : cfg_percentile;
    fill_nxt = (fill_r < eff_c) ? fill_r + 1'b1 : eff_c;
    k_over_c = |prod_r[FW+PCT_W-1:FW+16];
    k_c = prod_r[FW+15:16];
    grew_c = !s_r.signed_change[CHG_W-1] && (s_r.signed_change != '0);
  end

  assign snap_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && snap_valid && !snap.baseline)
      win_mem[wpos_r] <= snap.magnitude;
    rd_r <= win_mem[rpos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; wpos_r <= '0; fill_r <= '0; obs_r <= '0;
      res.valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (snap_valid) begin
            s_r <= snap;
            if (snap.baseline) begin
              res.is_spike <= 1'b0; res.direction <= DIR_NONE;
              res.winning_side <= SIDE_NONE; res.winning_price <= '0;
              res.signed_change <= '0; res.valid <= 1'b1;
              state_r <= S_OUT;
            end else begin
              wpos_r <= (32'(wpos_r) == WINDOW_MAX - 1) ? '0 : wpos_r + 1'b1;
              fill_r <= fill_nxt;
              if (obs_r != '1) obs_r <= obs_r + 1'b1;
              prod_r <= fill_nxt * pct_c;
              rpos_r <= wpos_r;
              state_r <= S_RANK;
            end
          end
        end
        S_RANK: begin
          test_r  <= !k_over_c && (k_c < fill_r) && (obs_r >= cfg_min_obs);
          left_r  <= fill_r;
          below_r <= '0;
          rd_ok_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // One entry a cycle, newest first; data arrives in the cycle after its address.
          if (rd_ok_r && rd_r < s_r.magnitude) below_r <= below_r + 1'b1;
          if (left_r != '0) begin
            rd_ok_r <= 1'b1;
            rpos_r <= (rpos_r == '0) ? PW'(WINDOW_MAX - 1) : rpos_r - 1'b1;
            left_r <= left_r - 1'b1;
          end else begin
            rd_ok_r <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          res.is_spike <= test_r && (below_r > k_c);
          res.direction <= (test_r && (below_r > k_c)) ?
            (((s_r.side == SIDE_BID) == grew_c) ? DIR_BULLISH : DIR_BEARISH) : DIR_NONE;
          res.winning_side <= s_r.side;
          res.winning_price <= s_r.price;
          res.signed_change <= s_r.signed_change;
          res.valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) begin
            res.valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/book_level_change_spike_detector_core.sv]
// Top level of the book level change spike detector.
// Levels arrive on in_ (valid/ready), bids then asks, last_level closing each
// snapshot. Results leave on out_ (valid/ready), one beat per snapshot.
// In the front part each level beat is first accepted, reading the previous
// size while writing the new one, and then compared against the running best.
// After the closing beat the front part hands its summary to a two-entry
// queue. The back part pushes the change into the rolling window and scans
// it one entry a cycle, then raises out_valid; a baseline snapshot skips the
// push and scan. The back part takes no new snapshot until its result is
// taken, and the front part takes no new level while it is comparing.
// The scan runs while the front part already takes the next snapshot's levels.
// The first snapshot after reset only stores a baseline; its result is zero.
// Reset (rst_n low at a clock edge) empties the window, counts and queue;
// stored book sizes are never used until rewritten.
// When the receiver stalls, the result holds, the queue fills, and the
// front part then holds in_ready low at snapshot end.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
`default_nettype none
module book_level_change_spike_detector_core #(
  parameter int unsigned BOOK_DEPTH = 32,
  parameter int unsigned WINDOW_MAX = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [16:0]  cfg_data,
  blcsd_level_if.sink       in_lvl,
  blcsd_result_if.source    out_res
);
  import blcsd_pkg::*;
  logic [WSIZE_W-1:0] wsize_r;
  logic [PCT_W-1:0]   pct_r;
  logic [OBS_W-1:0]   minobs_r;
  logic  f_valid, f_ready, b_valid, b_ready;
  snap_t f_snap, b_snap;

  // Config registers; the sender must write them only while idle (unenforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= 9'd100; pct_r <= 17'd62259; minobs_r <= 16'd100;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW_SIZE: wsize_r  <= cfg_data[WSIZE_W-1:0];
        REG_PERCENTILE:  pct_r    <= cfg_data;
        REG_MIN_OBS:     minobs_r <= cfg_data[OBS_W-1:0];
        default: ;
      endcase
    end
  end

  blcsd_front #(.BOOK_DEPTH(BOOK_DEPTH)) u_front (
    .clk, .rst_n,
    .lvl_valid(in_lvl.valid), .lvl_ready(in_lvl.ready), .lvl_side(in_lvl.side),
    .lvl_size(in_lvl.level_size), .lvl_price(in_lvl.level_price),
    .lvl_last(in_lvl.last_level),
    .snap_valid(f_valid), .snap_ready(f_ready), .snap(f_snap)
  );

  blcsd_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_snap),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_snap)
  );

  blcsd_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk, .rst_n, .cfg_window_size(wsize_r), .cfg_percentile(pct_r),
    .cfg_min_obs(minobs_r), .snap_valid(b_valid), .snap_ready(b_ready),
    .snap(b_snap), .res(out_res)
  );
endmodule
`default_nettype wire

[src/blcsd_checker.sv]
// Port-level checker for the spike detector, bound to the top level.
`default_nettype none
module blcsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_spike,
  input wire logic [1:0]  direction,
  input wire logic [1:0]  winning_side,
  input wire logic [31:0] winning_price,
  input wire logic [31:0] signed_change
);
  a_dir_spike: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((direction != 2'd0) == is_spike)) else $error("direction without spike");
  a_side_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && winning_side == 2'd0 |-> signed_change == 32'd0 && winning_price == 32'd0)
    else $error("payload without winning side");
  a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> winning_side != 2'd3 && direction != 2'd3) else $error("bad code");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(signed_change)) else $error("result dropped");
endmodule

bind book_level_change_spike_detector_core blcsd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_res.valid), .out_ready(out_res.ready),
  .is_spike(out_res.is_spike), .direction(out_res.direction),
  .winning_side(out_res.winning_side), .winning_price(out_res.winning_price),
  .signed_change(out_res.signed_change)
);
`default_nettype wire
